[hdl/sobi_pkg.sv]
// Shared types and constants for the serial to one-wire bridge interpreter.
package sobi_pkg;

    localparam int SEARCH_BYTES = 16;
    localparam int PARAM_COUNT  = 8;

    // Result kinds
    localparam logic [1:0] KIND_HOST  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_BIT   = 2'd2;
    localparam logic [1:0] KIND_BYTE  = 2'd3;

    // Input opcodes
    localparam logic OP_HOST = 1'b0;
    localparam logic OP_BUS  = 1'b1;

    // Host byte constants
    localparam logic [7:0] CMD_DATA     = 8'hE1;
    localparam logic [7:0] CMD_ESCAPE   = 8'hE3;
    localparam logic [7:0] RPL_PRESENT  = 8'hCC;
    localparam logic [7:0] RPL_ABSENT   = 8'hCD;
    localparam logic [7:0] ROM_SEARCH   = 8'hF0;
    localparam logic [7:0] CFG_MASK     = 8'h7E;

    // Modes
    localparam logic [1:0] MODE_CMD   = 2'd0;
    localparam logic [1:0] MODE_XFER  = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    // Phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_COLLECT = 3'd1;
    localparam logic [2:0] PH_SRESET  = 3'd2;
    localparam logic [2:0] PH_SF0     = 3'd3;
    localparam logic [2:0] PH_READ1   = 3'd4;
    localparam logic [2:0] PH_READ2   = 3'd5;
    localparam logic [2:0] PH_WRITE   = 3'd6;
    localparam logic [2:0] PH_SINGLE  = 3'd7;

    // Pending single request tags
    localparam logic [1:0] TAG_BIT   = 2'd0;
    localparam logic [1:0] TAG_RESET = 2'd1;
    localparam logic [1:0] TAG_BYTE  = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] host_byte;
        logic       bus_bit;
        logic [7:0] bus_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] speed;
        logic       last;
    } t_out;

    // Front-to-back job: a single result, or the search reply burst
    typedef struct packed {
        logic burst;
        t_out res;
    } t_job;

endpackage

[hdl/serial_onewire_bridge_interpreter.sv]
// Top level of the serial to one-wire bridge interpreter.
// A one-entry job register parts the command decoder from the output stage,
// so a single result beat passes the job register and then the output
// register, and an accepted item yields at most one beat, but the final search
// write starts a reply burst of sixteen beats from the back end's reply store
// at one beat a cycle while the receiver does not stall; the input is held off
// while the burst plays out. Without output stalls an item can otherwise be
// accepted every cycle; a stalled output fills the job register and then holds
// off the input.
module serial_onewire_bridge_interpreter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sobi_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output sobi_pkg::t_out o_item
);

    logic           job_valid, job_ready;
    logic           busy;
    sobi_pkg::t_job job;
    logic           rpl_clear, rpl_we;
    logic [3:0]     rpl_idx;
    logic [7:0]     rpl_or;

    sobi_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .i_busy(busy), .o_job(job),
        .o_rpl_clear(rpl_clear), .o_rpl_we(rpl_we), .o_rpl_idx(rpl_idx),
        .o_rpl_or(rpl_or)
    );

    sobi_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .o_busy(busy), .i_job(job),
        .i_rpl_clear(rpl_clear), .i_rpl_we(rpl_we), .i_rpl_idx(rpl_idx),
        .i_rpl_or(rpl_or), .o_valid, .i_ready, .o_item
    );

endmodule

[hdl/sobi_front.sv]
// Front end: accepts items, runs the mode and phase machine, queues jobs.
module sobi_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sobi_pkg::t_in         i_item,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    input  logic                  i_busy,
    output sobi_pkg::t_job        o_job,
    output logic                  o_rpl_clear,
    output logic                  o_rpl_we,
    output logic [3:0]            o_rpl_idx,
    output logic [7:0]            o_rpl_or
);

    logic [1:0] r_mode, n_mode;
    logic       r_search, n_search;
    logic       r_pullup, n_pullup;
    logic [1:0] r_speed, n_speed;
    logic [2:0] r_param [sobi_pkg::PARAM_COUNT];
    logic [7:0] r_req   [sobi_pkg::SEARCH_BYTES];
    logic [4:0] r_count, n_count;
    logic [5:0] r_pair, n_pair;
    logic [2:0] r_phase, n_phase;
    logic       r_first, n_first;

    logic       r_qv;
    sobi_pkg::t_job r_q;
    logic       emit;
    sobi_pkg::t_job job;
    logic       p_we;
    logic [2:0] p_idx, p_val;
    logic       q_we;
    logic [3:0] q_idx;
    logic [7:0] hb;
    logic       go_data, go_cmd;
    logic [1:0] cur_speed;
    logic [7:0] rq_byte;
    logic       rn, b2, dd;
    logic [1:0] jj;

    // Hold the input while the job register is full and not taken, or while the back end plays out a reply burst
    assign o_ready     = (!r_qv || i_job_ready) && !i_busy;
    assign o_job_valid = r_qv;
    assign o_job       = r_q;
    assign hb          = i_item.host_byte;

    always_comb begin
        rq_byte = r_req[r_pair[5:2]];
        jj      = r_pair[1:0];
        rn      = rq_byte[{jj, 1'b1}];
    end

    // Decode one accepted item
    always_comb begin
        n_mode = r_mode; n_search = r_search; n_pullup = r_pullup;
        n_speed = r_speed; n_count = r_count; n_pair = r_pair;
        n_phase = r_phase; n_first = r_first;
        emit = 1'b0; job = '0;
        p_we = 1'b0; p_idx = '0; p_val = '0;
        q_we = 1'b0; q_idx = '0;
        o_rpl_clear = 1'b0; o_rpl_we = 1'b0; o_rpl_idx = r_pair[5:2]; o_rpl_or = '0;
        go_data = 1'b0; go_cmd = 1'b0;
        dd = 1'b0; b2 = 1'b0;
        cur_speed = r_speed;
        if (i_item.opcode == sobi_pkg::OP_HOST) begin
            if (r_phase == sobi_pkg::PH_COLLECT) begin
                q_we  = 1'b1;
                q_idx = r_count[3:0];
                if (r_count == 5'(sobi_pkg::SEARCH_BYTES - 1)) begin
                    n_count = '0;
                    o_rpl_clear = 1'b1;
                    n_phase = sobi_pkg::PH_SRESET;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_RESET;
                end else begin
                    n_count = r_count + 5'd1;
                end
            end else if (r_phase == sobi_pkg::PH_IDLE) begin
                case (r_mode)
                    sobi_pkg::MODE_XFER: begin
                        if (hb == sobi_pkg::CMD_ESCAPE) n_mode = sobi_pkg::MODE_CHECK;
                        else go_data = 1'b1;
                    end
                    sobi_pkg::MODE_CHECK: begin
                        if (hb == sobi_pkg::CMD_ESCAPE) begin
                            n_mode = sobi_pkg::MODE_XFER;
                            go_data = 1'b1;
                        end else go_cmd = 1'b1;
                    end
                    default: go_cmd = 1'b1;
                endcase
            end
            if (go_data) begin
                if (r_search) begin
                    q_we = 1'b1; q_idx = '0;
                    n_count = 5'd1;
                    n_phase = sobi_pkg::PH_COLLECT;
                end else begin
                    n_count = 5'(sobi_pkg::TAG_BYTE);
                    n_phase = sobi_pkg::PH_SINGLE;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_BYTE;
                    job.res.value = hb;
                end
            end
            if (go_cmd) begin
                if (hb == sobi_pkg::CMD_DATA) begin
                    n_mode = sobi_pkg::MODE_XFER;
                end else begin
                    n_mode = sobi_pkg::MODE_CMD;
                    if (hb[7] == 1'b0 && hb[0]) begin
                        emit = 1'b1;
                        job.res.kind = sobi_pkg::KIND_HOST;
                        if (hb[6:4] == 3'd0) begin
                            job.res.value = {1'b0, hb[3:1], r_param[hb[3:1]], 1'b0};
                        end else begin
                            p_we = 1'b1; p_idx = hb[6:4]; p_val = hb[3:1];
                            job.res.value = hb & sobi_pkg::CFG_MASK;
                        end
                    end else if (hb[7] && hb[0]) begin
                        case (hb[6:5])
                            2'b00: begin
                                n_speed = hb[3:2]; cur_speed = hb[3:2];
                                n_first = hb[4];
                                n_count = 5'(sobi_pkg::TAG_BIT);
                                n_phase = sobi_pkg::PH_SINGLE;
                                emit = 1'b1;
                                job.res.kind = sobi_pkg::KIND_BIT;
                                job.res.value = {7'd0, hb[4]};
                            end
                            2'b10: begin
                                n_speed = hb[3:2]; cur_speed = hb[3:2];
                                n_count = 5'(sobi_pkg::TAG_RESET);
                                n_phase = sobi_pkg::PH_SINGLE;
                                emit = 1'b1;
                                job.res.kind = sobi_pkg::KIND_RESET;
                            end
                            2'b01: begin
                                n_search = hb[4];
                                n_speed = hb[3:2];
                            end
                            default: begin
                                n_pullup = hb[1];
                                emit = 1'b1;
                                job.res.kind = sobi_pkg::KIND_HOST;
                                job.res.value = hb;
                            end
                        endcase
                    end
                end
            end
        end else begin
            case (r_phase)
                sobi_pkg::PH_SRESET: begin
                    n_phase = sobi_pkg::PH_SF0;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_BYTE;
                    job.res.value = sobi_pkg::ROM_SEARCH;
                end
                sobi_pkg::PH_SF0: begin
                    n_pair = '0;
                    n_phase = sobi_pkg::PH_READ1;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_BIT;
                    job.res.value = 8'd1;
                end
                sobi_pkg::PH_READ1: begin
                    n_first = i_item.bus_bit;
                    n_phase = sobi_pkg::PH_READ2;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_BIT;
                    job.res.value = 8'd1;
                end
                sobi_pkg::PH_READ2: begin
                    if (r_first == i_item.bus_bit) begin
                        dd = 1'b1; b2 = rn;
                    end else begin
                        dd = 1'b0; b2 = r_first;
                    end
                    o_rpl_we = 1'b1;
                    o_rpl_or = 8'({b2, dd}) << {jj, 1'b0};
                    n_phase = sobi_pkg::PH_WRITE;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_BIT;
                    job.res.value = {7'd0, b2};
                end
                sobi_pkg::PH_WRITE: begin
                    emit = 1'b1;
                    if (r_pair == 6'(sobi_pkg::SEARCH_BYTES * 4 - 1)) begin
                        n_pair = '0;
                        n_phase = sobi_pkg::PH_IDLE;
                        job.burst = 1'b1;
                    end else begin
                        n_pair = r_pair + 6'd1;
                        n_phase = sobi_pkg::PH_READ1;
                        job.res.kind = sobi_pkg::KIND_BIT;
                        job.res.value = 8'd1;
                    end
                end
                sobi_pkg::PH_SINGLE: begin
                    n_phase = sobi_pkg::PH_IDLE;
                    n_count = '0;
                    emit = 1'b1;
                    job.res.kind = sobi_pkg::KIND_HOST;
                    if (r_count[1:0] == sobi_pkg::TAG_BIT)
                        job.res.value = {3'b100, r_first, r_speed,
                                         {2{i_item.bus_bit}}};
                    else if (r_count[1:0] == sobi_pkg::TAG_RESET)
                        job.res.value = i_item.bus_bit ? sobi_pkg::RPL_PRESENT
                                                       : sobi_pkg::RPL_ABSENT;
                    else
                        job.res.value = i_item.bus_byte;
                end
                default: ;
            endcase
        end
        job.res.speed = cur_speed;
        job.res.last  = 1'b1;
        // Touch the reply store only on an accepted beat
        o_rpl_clear = o_rpl_clear && i_valid && o_ready;
        o_rpl_we    = o_rpl_we && i_valid && o_ready;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sobi_pkg::MODE_CMD; r_search <= 1'b0; r_pullup <= 1'b0;
            r_speed <= '0; r_count <= '0; r_pair <= '0;
            r_phase <= sobi_pkg::PH_IDLE; r_first <= 1'b0; r_qv <= 1'b0;
            for (int k = 0; k < sobi_pkg::PARAM_COUNT; k++)
                r_param[k] <= (k == 2 || k == 3) ? 3'd2 : 3'd0;
        end else begin
            if (i_valid && o_ready && emit) r_qv <= 1'b1;
            else if (i_job_ready) r_qv <= 1'b0;
            if (i_valid && o_ready) begin
                r_mode <= n_mode; r_search <= n_search; r_pullup <= n_pullup;
                r_speed <= n_speed; r_count <= n_count; r_pair <= n_pair;
                r_phase <= n_phase; r_first <= n_first;
                if (p_we) r_param[p_idx] <= p_val;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            if (emit) r_q <= job;
            if (q_we) r_req[q_idx] <= hb;
        end
    end

endmodule

[hdl/sobi_back.sv]
// Back end: holds the search reply and drives result beats, bursts included.
module sobi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    output logic            o_busy,
    input  sobi_pkg::t_job  i_job,
    input  logic            i_rpl_clear,
    input  logic            i_rpl_we,
    input  logic [3:0]      i_rpl_idx,
    input  logic [7:0]      i_rpl_or,
    output logic            o_valid,
    input  logic            i_ready,
    output sobi_pkg::t_out  o_item
);

    logic [7:0] r_rpl [sobi_pkg::SEARCH_BYTES];
    logic       r_busy;
    logic [3:0] r_idx;
    logic [1:0] r_speed;
    logic       r_ov;
    sobi_pkg::t_out r_o;
    logic       load;

    assign o_valid     = r_ov;
    assign o_item      = r_o;
    assign load        = !r_ov || i_ready;
    assign o_job_ready = load && !r_busy;
    assign o_busy      = r_busy;

    // Track the reply store, the output register and the burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_busy <= 1'b0; r_idx <= '0;
            for (int k = 0; k < sobi_pkg::SEARCH_BYTES; k++) r_rpl[k] <= '0;
        end else begin
            if (i_rpl_clear)
                for (int k = 0; k < sobi_pkg::SEARCH_BYTES; k++) r_rpl[k] <= '0;
            else if (i_rpl_we)
                r_rpl[i_rpl_idx] <= r_rpl[i_rpl_idx] | i_rpl_or;
            if (load) begin
                if (r_busy) begin
                    r_ov <= 1'b1;
                    r_o  <= '{sobi_pkg::KIND_HOST, r_rpl[r_idx], r_speed,
                              r_idx == 4'(sobi_pkg::SEARCH_BYTES - 1)};
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'(sobi_pkg::SEARCH_BYTES - 1)) r_busy <= 1'b0;
                end else if (i_job_valid) begin
                    if (i_job.burst) begin
                        r_busy <= 1'b1; r_idx <= '0; r_speed <= i_job.res.speed;
                        r_ov <= 1'b0;
                    end else begin
                        r_ov <= 1'b1;
                        r_o  <= i_job.res;
                    end
                end else begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

endmodule

[hdl/sobi_checker.sv]
// Port-level checks for the bridge interpreter, bound to the top level.
module sobi_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input sobi_pkg::t_out o_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result beat changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> o_item.kind == sobi_pkg::KIND_HOST)
        else $error("non-final beat that is not a host reply");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_item.last |=> o_valid)
        else $error("reply burst broke off");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> !o_ready)
        else $error("input taken during a reply burst");

endmodule

bind serial_onewire_bridge_interpreter sobi_checker u_sobi_checker (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready, .o_item
);

[tb/sv/serial_onewire_bridge_interpreter_chk.sv]
// Checker: watches both channels, predicts results and compares them.
module serial_onewire_bridge_interpreter_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           o_ready,
    input  sobi_pkg::t_in  i_item,
    input  logic           o_valid,
    input  logic           i_ready,
    input  sobi_pkg::t_out o_item,
    output int             o_fail_count,
    output int             o_pending
);

    logic [1:0] mode;
    logic       search_on;
    logic       pullup_arm;
    logic [1:0] speed_code;
    logic [2:0] params [sobi_pkg::PARAM_COUNT];
    logic [7:0] req_bytes [sobi_pkg::SEARCH_BYTES];
    logic [7:0] rom_reply [sobi_pkg::SEARCH_BYTES];
    logic [4:0] byte_cnt;
    logic [5:0] pair_idx;
    logic [2:0] phase;
    logic       first_bit;

    sobi_pkg::t_out expected_beats [$];

    assign o_pending = expected_beats.size();

    // Queue one expected beat at the current speed
    function automatic void push_beat(logic [1:0] kind, logic [7:0] value, logic last);
        sobi_pkg::t_out r;
        r.kind  = kind;
        r.value = value;
        r.speed = speed_code;
        r.last  = last;
        expected_beats.push_back(r);
    endfunction

    function automatic void data_byte(logic [7:0] b);
        if (search_on) begin
            req_bytes[0] = b;
            byte_cnt = 5'd1;
            phase = sobi_pkg::PH_COLLECT;
        end else begin
            byte_cnt = 5'(sobi_pkg::TAG_BYTE);
            phase = sobi_pkg::PH_SINGLE;
            push_beat(sobi_pkg::KIND_BYTE, b, 1'b1);
        end
    endfunction

    function automatic void command_byte(logic [7:0] b);
        logic [2:0] sel;
        logic [2:0] val;
        if (b == sobi_pkg::CMD_DATA) begin
            mode = sobi_pkg::MODE_XFER;
            return;
        end
        mode = sobi_pkg::MODE_CMD;
        sel = b[6:4];
        val = b[3:1];
        if (b[7] == 1'b0 && b[0] == 1'b1) begin
            if (sel == 3'd0) begin
                push_beat(sobi_pkg::KIND_HOST, {1'b0, val, params[val], 1'b0}, 1'b1);
            end else begin
                params[sel] = val;
                push_beat(sobi_pkg::KIND_HOST, b & sobi_pkg::CFG_MASK, 1'b1);
            end
            return;
        end
        if (!(b[7] && b[0])) return;
        case (b[6:5])
            2'b00: begin
                speed_code = b[3:2];
                first_bit = b[4];
                byte_cnt = 5'(sobi_pkg::TAG_BIT);
                phase = sobi_pkg::PH_SINGLE;
                push_beat(sobi_pkg::KIND_BIT, {7'd0, first_bit}, 1'b1);
            end
            2'b10: begin
                speed_code = b[3:2];
                byte_cnt = 5'(sobi_pkg::TAG_RESET);
                phase = sobi_pkg::PH_SINGLE;
                push_beat(sobi_pkg::KIND_RESET, 8'd0, 1'b1);
            end
            2'b01: begin
                search_on = b[4];
                speed_code = b[3:2];
            end
            default: begin
                pullup_arm = b[1];
                push_beat(sobi_pkg::KIND_HOST, b, 1'b1);
            end
        endcase
    endfunction

    function automatic void host_beat(logic [7:0] b);
        if (phase == sobi_pkg::PH_COLLECT) begin
            if (byte_cnt < sobi_pkg::SEARCH_BYTES) req_bytes[byte_cnt[3:0]] = b;
            byte_cnt = byte_cnt + 5'd1;
            if (byte_cnt >= sobi_pkg::SEARCH_BYTES) begin
                byte_cnt = 5'd0;
                foreach (rom_reply[k]) rom_reply[k] = 8'd0;
                phase = sobi_pkg::PH_SRESET;
                push_beat(sobi_pkg::KIND_RESET, 8'd0, 1'b1);
            end
            return;
        end
        if (phase >= sobi_pkg::PH_SRESET) return;
        if (mode == sobi_pkg::MODE_XFER) begin
            if (b == sobi_pkg::CMD_ESCAPE) mode = sobi_pkg::MODE_CHECK;
            else data_byte(b);
        end else if (mode == sobi_pkg::MODE_CHECK) begin
            if (b == sobi_pkg::CMD_ESCAPE) begin
                mode = sobi_pkg::MODE_XFER;
                data_byte(b);
            end else begin
                command_byte(b);
            end
        end else begin
            command_byte(b);
        end
    endfunction

    function automatic void bus_beat(logic bit_in, logic [7:0] byte_in);
        logic [3:0] i;
        logic [2:0] j;
        logic       rn;
        logic       d;
        logic       b2;
        case (phase)
            sobi_pkg::PH_SRESET: begin
                phase = sobi_pkg::PH_SF0;
                push_beat(sobi_pkg::KIND_BYTE, sobi_pkg::ROM_SEARCH, 1'b1);
            end
            sobi_pkg::PH_SF0: begin
                pair_idx = 6'd0;
                phase = sobi_pkg::PH_READ1;
                push_beat(sobi_pkg::KIND_BIT, 8'd1, 1'b1);
            end
            sobi_pkg::PH_READ1: begin
                first_bit = bit_in;
                phase = sobi_pkg::PH_READ2;
                push_beat(sobi_pkg::KIND_BIT, 8'd1, 1'b1);
            end
            sobi_pkg::PH_READ2: begin
                i = pair_idx[5:2];
                j = {pair_idx[1:0], 1'b0};
                rn = req_bytes[i][j + 3'd1];
                if (first_bit == bit_in) begin
                    d = 1'b1;
                    b2 = rn;
                end else begin
                    d = 1'b0;
                    b2 = first_bit;
                end
                rom_reply[i] = rom_reply[i] | (8'({b2, d}) << j);
                phase = sobi_pkg::PH_WRITE;
                push_beat(sobi_pkg::KIND_BIT, {7'd0, b2}, 1'b1);
            end
            sobi_pkg::PH_WRITE: begin
                if (pair_idx == 6'd63) begin
                    pair_idx = 6'd0;
                    phase = sobi_pkg::PH_IDLE;
                    for (int k = 0; k < sobi_pkg::SEARCH_BYTES; k++)
                        push_beat(sobi_pkg::KIND_HOST, rom_reply[k],
                                  k == sobi_pkg::SEARCH_BYTES - 1);
                end else begin
                    pair_idx = pair_idx + 6'd1;
                    phase = sobi_pkg::PH_READ1;
                    push_beat(sobi_pkg::KIND_BIT, 8'd1, 1'b1);
                end
            end
            sobi_pkg::PH_SINGLE: begin
                phase = sobi_pkg::PH_IDLE;
                if (byte_cnt == 5'(sobi_pkg::TAG_BIT))
                    push_beat(sobi_pkg::KIND_HOST,
                              {3'b100, first_bit, speed_code, bit_in, bit_in}, 1'b1);
                else if (byte_cnt == 5'(sobi_pkg::TAG_RESET))
                    push_beat(sobi_pkg::KIND_HOST,
                              bit_in ? sobi_pkg::RPL_PRESENT : sobi_pkg::RPL_ABSENT, 1'b1);
                else
                    push_beat(sobi_pkg::KIND_HOST, byte_in, 1'b1);
                byte_cnt = 5'd0;
            end
            default: ;
        endcase
    endfunction

    // Track state on each accepted beat and compare each result beat
    always @(posedge i_clk) begin
        sobi_pkg::t_out exp_beat;
        if (!i_rst_n) begin
            mode <= sobi_pkg::MODE_CMD;
            search_on <= 1'b0;
            pullup_arm <= 1'b0;
            speed_code <= 2'd0;
            foreach (params[k]) params[k] <= (k == 2 || k == 3) ? 3'd2 : 3'd0;
            foreach (req_bytes[k]) req_bytes[k] <= 8'd0;
            foreach (rom_reply[k]) rom_reply[k] <= 8'd0;
            byte_cnt <= 5'd0;
            pair_idx <= 6'd0;
            phase <= sobi_pkg::PH_IDLE;
            first_bit <= 1'b0;
            o_fail_count <= 0;
            expected_beats.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: expected no beat, got %h", $time, o_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (exp_beat !== o_item) begin
                        $display("%0t: expected kind %0d value %h speed %0d last %0d,",
                                 $time, exp_beat.kind, exp_beat.value, exp_beat.speed,
                                 exp_beat.last);
                        $display("%0t: got kind %0d value %h speed %0d last %0d",
                                 $time, o_item.kind, o_item.value, o_item.speed,
                                 o_item.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_item.opcode == sobi_pkg::OP_BUS)
                    bus_beat(i_item.bus_bit, i_item.bus_byte);
                else
                    host_beat(i_item.host_byte);
            end
        end
    end

endmodule

[tb/sv/serial_onewire_bridge_interpreter_tb.sv]
// Testbench top: drives host bytes and bus results, and reports the verdict.
module serial_onewire_bridge_interpreter_tb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    sobi_pkg::t_in  i_item = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    sobi_pkg::t_out o_item;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   hold_off = 1'b0;

    serial_onewire_bridge_interpreter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    serial_onewire_bridge_interpreter_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item       (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort on a runaway run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("serial_onewire_bridge_interpreter: mismatch");
            $finish;
        end
    end

    // Offer one beat, wait for acceptance, then pause a random gap
    task automatic send_beat(logic op, logic [7:0] hb, logic bb, logic [7:0] by);
        int gap;
        sobi_pkg::t_in it;
        it.opcode = op;
        it.host_byte = hb;
        it.bus_bit = bb;
        it.bus_byte = by;
        i_item <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic host(logic [7:0] b);
        send_beat(sobi_pkg::OP_HOST, b, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic bus(logic bb, logic [7:0] by);
        send_beat(sobi_pkg::OP_BUS, 8'($urandom_range(0, 255)), bb, by);
    endtask

    // Full search: turn search on, enter data mode, 16 request bytes, then all bus replies
    task automatic rom_search;
        host({4'b1011, 1'($urandom_range(0, 1)), 3'b001});
        host(sobi_pkg::CMD_DATA);
        repeat (16) host(8'($urandom_range(0, 255)));
        bus(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        bus(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        repeat (64) begin
            bus(1'($urandom_range(0, 1)), 8'd0);
            bus(1'($urandom_range(0, 1)), 8'd0);
            bus(1'($urandom_range(0, 1)), 8'd0);
        end
        host(sobi_pkg::CMD_ESCAPE);
        host(8'hA1);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (stall == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int sel;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: config reads and writes, commands, escape, single ops
        host(8'h05);
        host(8'h71);
        host(8'h0F);
        host(8'h00);
        host(8'hFE);
        host(8'h8D);
        bus(1'b1, 8'h00);
        host(8'h91);
        bus(1'b0, 8'h00);
        host(8'hCD);
        bus(1'b1, 8'h00);
        host(8'hC1);
        bus(1'b0, 8'h00);
        host(8'hEF);
        host(8'hE1);
        host(8'hFF);
        host(8'h33);
        bus(1'b0, 8'hA5);
        host(sobi_pkg::CMD_ESCAPE);
        host(sobi_pkg::CMD_ESCAPE);
        bus(1'b1, 8'h5A);
        host(sobi_pkg::CMD_ESCAPE);
        host(8'hA1);
        bus(1'b1, 8'h00);

        // Long hold-off on results while beats keep arriving
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            rom_search();
        join

        // Random: mostly well-formed sequences, some noise
        repeat (10) begin
            sel = $urandom_range(1, 9);
            if (sel < 4) begin
                host({1'b1, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b1});
                bus(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (sel < 6) begin
                host({1'b0, 6'($urandom_range(0, 63)), 1'b1});
            end else if (sel < 8) begin
                host(sobi_pkg::CMD_DATA);
                host(8'($urandom_range(0, 255)));
                bus(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                host(sobi_pkg::CMD_ESCAPE);
                host(8'($urandom_range(0, 255)));
            end else begin
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("serial_onewire_bridge_interpreter: match");
        else
            $display("serial_onewire_bridge_interpreter: mismatch");
        $finish;
    end

endmodule

[sim.f]
hdl/sobi_pkg.sv
hdl/sobi_front.sv
hdl/sobi_back.sv
hdl/serial_onewire_bridge_interpreter.sv
hdl/sobi_checker.sv
tb/sv/serial_onewire_bridge_interpreter_chk.sv
tb/sv/serial_onewire_bridge_interpreter_tb.sv
